/* src/gie_pkg.sv */
// Shared types and constants for the GF(2^m) extended-Euclid inverter.
// Used by the channel interfaces, the cell row, the sequencer and the top level.
package gie_pkg;

    localparam int FIELD_DEGREE_DEF = 10;
    localparam int MODULUS_RESET    = 1033;   // x^10 + x^3 + 1

    // Operation broadcast to every cell of the row.
    typedef enum logic [2:0] {
        OP_HOLD,
        OP_LOAD,
        OP_NORM,
        OP_STEP,
        OP_STEP_SWAP,
        OP_SWAP
    } t_cell_op;

    typedef struct packed {
        t_cell_op op;
        logic     shift_a;   // normalize the older remainder by one place
        logic     shift_b;   // normalize the newer remainder by one place
        logic     q;         // current quotient bit
    } t_cell_ctl;

    // Summary of the row seen by the sequencer.
    typedef struct packed {
        logic a_msb;
        logic a_nz;
        logic b_msb;
        logic b_nz;
    } t_chain_stat;

endpackage

/* src/gie_in_if.sv */
// Request channel carrying the operand to invert.
// Depends on gie_pkg for the default field degree.
interface gie_in_if
    import gie_pkg::*;
#(
    parameter int FIELD_DEGREE = FIELD_DEGREE_DEF
);
    logic                    valid;
    logic                    ready;
    logic [FIELD_DEGREE-1:0] operand;

    modport source (output valid, output operand, input ready);
    modport sink   (input valid, input operand, output ready);
endinterface

/* src/gie_out_if.sv */
// Result channel carrying the inverse and the invertible flag.
// Depends on gie_pkg for the default field degree.
interface gie_out_if
    import gie_pkg::*;
#(
    parameter int FIELD_DEGREE = FIELD_DEGREE_DEF
);
    logic                    valid;
    logic                    ready;
    logic [FIELD_DEGREE-1:0] inverse;
    logic                    invertible;

    modport source (output valid, output inverse, output invertible, input ready);
    modport sink   (input valid, input inverse, input invertible, output ready);
endinterface

/* src/gie_cell.sv */
// One bit slice of the inverter row: remainder, cofactor and product bits.
// Depends on gie_pkg for the control word.
module gie_cell
    import gie_pkg::*;
(
    input  logic      i_clk,
    input  t_cell_ctl i_ctl,
    input  logic      i_ld_a,
    input  logic      i_ld_b,
    input  logic      i_ld_cn,
    input  logic      i_a_lo,
    input  logic      i_b_lo,
    input  logic      i_acc_lo,
    output logic      o_a,
    output logic      o_b,
    output logic      o_co,
    output logic      o_acc
);

    logic r_a;
    logic r_b;
    logic r_co;
    logic r_cn;
    logic r_acc;
    logic a_step;
    logic acc_step;

    // One long-division step: subtract the divisor, shift up; Horner step on q*cn.
    assign a_step   = i_a_lo ^ (i_ctl.q & i_b_lo);
    assign acc_step = i_acc_lo ^ (i_ctl.q & r_cn);

    always_ff @(posedge i_clk) begin
        case (i_ctl.op)
            OP_LOAD: begin
                r_a   <= i_ld_a;
                r_b   <= i_ld_b;
                r_co  <= 1'b0;
                r_cn  <= i_ld_cn;
                r_acc <= 1'b0;
            end
            OP_NORM: begin
                if (i_ctl.shift_a) begin
                    r_a <= i_a_lo;
                end
                if (i_ctl.shift_b) begin
                    r_b <= i_b_lo;
                end
                r_acc <= 1'b0;
            end
            OP_STEP: begin
                r_a   <= a_step;
                r_acc <= acc_step;
            end
            OP_STEP_SWAP: begin
                r_a   <= r_b;
                r_b   <= a_step;
                r_co  <= r_cn;
                r_cn  <= r_co ^ acc_step;
                r_acc <= 1'b0;
            end
            OP_SWAP: begin
                r_a   <= r_b;
                r_b   <= r_a;
                r_co  <= r_cn;
                r_cn  <= r_co;
                r_acc <= 1'b0;
            end
            default: begin
                r_a <= r_a;
            end
        endcase
    end

    assign o_a   = r_a;
    assign o_b   = r_b;
    assign o_co  = r_co;
    assign o_acc = r_acc;

endmodule

/* src/gie_ctrl.sv */
// Sequencer of the inverter: degree counters, round control and result register.
// Depends on gie_pkg for the cell control word and the row status.
module gie_ctrl
    import gie_pkg::*;
#(
    parameter int FIELD_DEGREE = FIELD_DEGREE_DEF
)(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_ready,
    output logic                    o_out_valid,
    input  logic                    i_out_ready,
    output logic [FIELD_DEGREE-1:0] o_inverse,
    output logic                    o_invertible,
    input  t_chain_stat             i_stat,
    input  logic [FIELD_DEGREE-1:0] i_co,
    output t_cell_ctl               o_ctl
);

    localparam int             DEGW    = $clog2(FIELD_DEGREE + 1);
    localparam logic [DEGW-1:0] DEG_TOP = DEGW'(FIELD_DEGREE);

    typedef enum logic [1:0] {
        S_IDLE,
        S_NORM,
        S_DIV,
        S_DONE
    } t_state;

    t_state                  r_state;
    t_state                  n_state;
    logic [DEGW-1:0]         r_da;
    logic [DEGW-1:0]         n_da;
    logic [DEGW-1:0]         r_db;
    logic [DEGW-1:0]         n_db;
    logic                    r_first;
    logic                    n_first;
    logic                    r_ok;
    logic                    n_ok;
    logic                    r_out_valid;
    logic                    n_out_valid;
    logic [FIELD_DEGREE-1:0] r_inverse;
    logic [FIELD_DEGREE-1:0] n_inverse;
    logic                    r_invertible;
    logic                    n_invertible;
    logic                    a_need;
    logic                    b_need;
    logic                    older_one;

    assign a_need    = i_stat.a_nz & ~i_stat.a_msb;
    assign b_need    = i_stat.b_nz & ~i_stat.b_msb;
    assign older_one = i_stat.a_msb && (r_da == '0);

    always_comb begin
        n_state       = r_state;
        n_da          = r_da;
        n_db          = r_db;
        n_first       = r_first;
        n_ok          = r_ok;
        n_out_valid   = r_out_valid & ~i_out_ready;
        n_inverse     = r_inverse;
        n_invertible  = r_invertible;
        o_ctl.op      = OP_HOLD;
        o_ctl.shift_a = 1'b0;
        o_ctl.shift_b = 1'b0;
        o_ctl.q       = i_stat.a_msb;

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_ctl.op = OP_LOAD;
                    n_da     = DEG_TOP;
                    n_db     = DEG_TOP;
                    n_first  = 1'b1;
                    n_state  = S_NORM;
                end
            end
            S_NORM: begin
                if (a_need || b_need) begin
                    o_ctl.op      = OP_NORM;
                    o_ctl.shift_a = a_need;
                    o_ctl.shift_b = b_need;
                    if (a_need) begin
                        n_da = r_da - DEGW'(1);
                    end
                    if (b_need) begin
                        n_db = r_db - DEGW'(1);
                    end
                end else if (!i_stat.b_nz || (!r_first && older_one)) begin
                    n_ok    = older_one;
                    n_state = S_DONE;
                end else if (r_da >= r_db) begin
                    if (r_da == r_db) begin
                        o_ctl.op = OP_STEP_SWAP;
                        n_da     = r_db;
                        n_db     = (r_db == '0) ? '0 : r_db - DEGW'(1);
                        n_first  = 1'b0;
                    end else begin
                        o_ctl.op = OP_STEP;
                        n_da     = r_da - DEGW'(1);
                        n_state  = S_DIV;
                    end
                end else begin
                    o_ctl.op = OP_SWAP;
                    n_da     = r_db;
                    n_db     = r_da;
                    n_first  = 1'b0;
                end
            end
            S_DIV: begin
                if (r_da == r_db) begin
                    o_ctl.op = OP_STEP_SWAP;
                    n_da     = r_db;
                    n_db     = (r_db == '0) ? '0 : r_db - DEGW'(1);
                    n_first  = 1'b0;
                    n_state  = S_NORM;
                end else begin
                    o_ctl.op = OP_STEP;
                    n_da     = r_da - DEGW'(1);
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid  = 1'b1;
                    n_inverse    = r_ok ? i_co : '0;
                    n_invertible = r_ok;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_first     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_first     <= n_first;
            r_out_valid <= n_out_valid;
        end
        r_da         <= n_da;
        r_db         <= n_db;
        r_ok         <= n_ok;
        r_inverse    <= n_inverse;
        r_invertible <= n_invertible;
    end

    assign o_in_ready   = (r_state == S_IDLE);
    assign o_out_valid  = r_out_valid;
    assign o_inverse    = r_inverse;
    assign o_invertible = r_invertible;

`ifndef ASSERT_OFF
    a_div_order : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_da >= r_db))
        else $error("division running with older degree below divisor degree");

    a_div_norm : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> i_stat.b_msb)
        else $error("divisor not normalized during division");

    a_start : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && i_in_valid) |=> (r_state == S_NORM && r_first))
        else $error("accepted request did not start a first round");

    a_zero_fail : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_invertible) |-> (r_inverse == '0))
        else $error("non-invertible result carries a nonzero inverse");
`endif

endmodule

/* src/gf2m_inverse_euclid.sv */
// Top level of the GF(2^m) inverter: modulus register, row of bit cells, sequencer.
// Depends on gie_pkg, gie_in_if, gie_out_if, gie_cell and gie_ctrl.
//
//  channel    dir  handshake          payload
//  i_req      in   valid/ready        operand[FIELD_DEGREE-1:0]
//  o_rsp      out  valid/ready        inverse[FIELD_DEGREE-1:0], invertible
//  cfg        in   i_cfg_we (no wait)  i_cfg_data[FIELD_DEGREE:0] = modulus_poly
//
// One request at a time: the accept edge loads the row, then normalize shifts,
// long-division steps and swaps follow in S_NORM and S_DIV; S_NORM detects the
// end and S_DONE writes the result register.
// Reset is synchronous and active low; it returns the sequencer to idle, clears
// the result valid and loads the modulus with x^10+x^3+1.
// A result waiting on o_rsp does not block the next request; only a finished
// inversion waits in place until the result register frees up.
module gf2m_inverse_euclid
    import gie_pkg::*;
#(
    parameter int                 FIELD_DEGREE = FIELD_DEGREE_DEF,
    parameter logic [FIELD_DEGREE:0] MODULUS_INIT = (FIELD_DEGREE + 1)'(MODULUS_RESET)
)(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    gie_in_if.sink                i_req,
    gie_out_if.source             o_rsp,
    input  logic                  i_cfg_we,
    input  logic [FIELD_DEGREE:0] i_cfg_data
);

    localparam int W = FIELD_DEGREE + 1;

    // Remainders are kept left-justified: bit W-1 is the leading term once
    // normalized, and the sequencer tracks each degree in a counter. The
    // cofactors stay right-justified; the quotient times the newer cofactor is
    // built bit by bit in the product row as quotient bits come out, top first.
    logic [W-1:0] r_modulus;
    logic [W-1:0] w_a;
    logic [W-1:0] w_b;
    logic [W-1:0] w_co;
    logic [W-1:0] w_acc;
    logic [W-1:0] w_a_lo;
    logic [W-1:0] w_b_lo;
    logic [W-1:0] w_acc_lo;
    logic [W-1:0] w_ld_b;
    logic [W-1:0] w_ld_cn;
    t_cell_ctl    w_ctl;
    t_chain_stat  w_stat;

    // Modulus register: the user writes it only while idle; the block does not enforce it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_modulus <= MODULUS_INIT;
        end else if (i_cfg_we) begin
            r_modulus <= i_cfg_data;
        end
    end

    // Each cell takes its lower neighbor's bits; the bottom cell takes zeros.
    assign w_a_lo   = {w_a[W-2:0], 1'b0};
    assign w_b_lo   = {w_b[W-2:0], 1'b0};
    assign w_acc_lo = {w_acc[W-2:0], 1'b0};

    // Load: older remainder = modulus, newer = operand, cofactors (0, 1).
    assign w_ld_b  = {1'b0, i_req.operand};
    assign w_ld_cn = W'(1);

    for (genvar gi = 0; gi < W; gi++) begin : g_cell
        gie_cell u_cell (
            .i_clk    (i_clk),
            .i_ctl    (w_ctl),
            .i_ld_a   (r_modulus[gi]),
            .i_ld_b   (w_ld_b[gi]),
            .i_ld_cn  (w_ld_cn[gi]),
            .i_a_lo   (w_a_lo[gi]),
            .i_b_lo   (w_b_lo[gi]),
            .i_acc_lo (w_acc_lo[gi]),
            .o_a      (w_a[gi]),
            .o_b      (w_b[gi]),
            .o_co     (w_co[gi]),
            .o_acc    (w_acc[gi])
        );
    end

    // Leading-term and zero flags of both remainders for the sequencer.
    assign w_stat.a_msb = w_a[W-1];
    assign w_stat.a_nz  = |w_a;
    assign w_stat.b_msb = w_b[W-1];
    assign w_stat.b_nz  = |w_b;

    gie_ctrl #(
        .FIELD_DEGREE (FIELD_DEGREE)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_req.valid),
        .o_in_ready   (i_req.ready),
        .o_out_valid  (o_rsp.valid),
        .i_out_ready  (o_rsp.ready),
        .o_inverse    (o_rsp.inverse),
        .o_invertible (o_rsp.invertible),
        .i_stat       (w_stat),
        .i_co         (w_co[FIELD_DEGREE-1:0]),
        .o_ctl        (w_ctl)
    );

endmodule

/* tb/sv/gf2m_inverse_euclid_test.sv */
// Self-checking bench for gf2m_inverse_euclid: drives operands, predicts each inverse
// with a bit-level extended Euclid over GF(2)[x], and checks every returned result.
// Depends on gie_pkg, gie_in_if, gie_out_if and the gf2m_inverse_euclid top level.
module gf2m_inverse_euclid_test
    import gie_pkg::*;
();

    localparam int DEG          = FIELD_DEGREE_DEF;
    localparam int STALL_CYCLES = 300;       // long receiver hold-off, in clock cycles
    localparam int SETTLE       = 2 * DEG + 5; // drain time before the final verdict
    localparam int LIMIT_TIME   = 2000000;

    typedef struct packed {
        logic [DEG-1:0] inverse;
        logic           invertible;
    } t_inv_result;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic i_cfg_we;
    logic [DEG:0] i_cfg_data;

    gie_in_if  #(.FIELD_DEGREE(DEG)) req_ch ();
    gie_out_if #(.FIELD_DEGREE(DEG)) rsp_ch ();

    gf2m_inverse_euclid dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (req_ch),
        .o_rsp      (rsp_ch),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data)
    );

    // Operands waiting to be offered, and inverses predicted for accepted requests.
    logic [DEG-1:0] operands_to_send[$];
    t_inv_result    pending_inverses[$];

    logic [DEG:0] modulus_now;   // bench copy of the modulus register
    bit           req_taken;     // a request was accepted at the last rising edge
    bit           steady;        // suppress random idling on both sides
    bit           stall_go;      // arm the long receiver hold-off
    bit           rsp_hold;      // receiver hold-off in progress
    int           mismatches;

    always #2 i_clk = ~i_clk;

    // Degree of a polynomial over GF(2); -1 for zero.
    function automatic int poly_deg(input logic [63:0] p);
        int d;
        d = -1;
        for (int i = 0; i < 64; i++) begin
            if (p[i]) d = i;
        end
        return d;
    endfunction

    // Extended Euclid: remainders start at (modulus, operand), cofactors at (0, 1).
    // Stop when the newer remainder is zero or right after the older one hits one.
    function automatic t_inv_result euclid_inverse(input logic [DEG:0] modulus,
                                                   input logic [DEG-1:0] operand);
        logic [63:0] r_old, r_new, c_old, c_new, c_next, quot, rem, prod, mul_x, mul_y;
        int          d_num, d_den;
        bit          done;
        t_inv_result res;
        r_old = 64'(modulus);
        r_new = 64'(operand);
        c_old = '0;
        c_new = 64'd1;
        done  = 1'b0;
        while (r_new != 0 && !done) begin
            // carry-less long division of the older remainder by the newer one
            quot  = '0;
            rem   = r_old;
            d_den = poly_deg(r_new);
            d_num = poly_deg(rem);
            while (d_num >= d_den) begin
                quot[d_num - d_den] = 1'b1;
                rem   = rem ^ (r_new << (d_num - d_den));
                d_num = poly_deg(rem);
            end
            // carry-less product of quotient and newer cofactor
            prod  = '0;
            mul_x = quot;
            mul_y = c_new;
            while (mul_y != 0) begin
                if (mul_y[0]) prod = prod ^ mul_x;
                mul_x = mul_x << 1;
                mul_y = mul_y >> 1;
            end
            c_next = c_old ^ prod;
            r_old  = r_new;
            r_new  = rem;
            c_old  = c_new;
            c_new  = c_next;
            if (r_old == 64'd1) done = 1'b1;
        end
        res.invertible = (r_old == 64'd1);
        res.inverse    = res.invertible ? c_old[DEG-1:0] : '0;
        return res;
    endfunction

    // Idle with a chance of 38 in a hundred unless a steady stretch is running.
    function automatic bit take_break();
        return !steady && ($urandom_range(99) < 38);
    endfunction

    // Sender: hold a request until it is accepted, then offer the next one or idle.
    always @(negedge i_clk) begin
        if (i_rst_n && (!req_ch.valid || req_taken)) begin
            if (operands_to_send.size() != 0 && !take_break()) begin
                req_ch.valid   <= 1'b1;
                req_ch.operand <= operands_to_send[0];
            end else begin
                req_ch.valid   <= 1'b0;
                req_ch.operand <= DEG'($urandom);
            end
        end
    end

    // Receiver: drop ready at random, and for the whole hold-off window.
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            rsp_ch.ready <= !rsp_hold && !take_break();
        end
    end

    // Long hold-off on the result side, counted here while the sender keeps going,
    // so the block fills up and stalls its request channel.
    initial begin : rsp_stall
        wait (stall_go);
        @(posedge i_clk);
        rsp_hold = 1'b1;
        repeat (STALL_CYCLES) @(posedge i_clk);
        rsp_hold = 1'b0;
    end

    // Monitor: predict on each accepted request, check each accepted result
    // against the oldest prediction.
    always @(posedge i_clk) begin : watch
        t_inv_result want;
        if (i_rst_n) begin
            req_taken <= req_ch.valid && req_ch.ready;
            if (req_ch.valid && req_ch.ready) begin
                pending_inverses.push_back(euclid_inverse(modulus_now, req_ch.operand));
                void'(operands_to_send.pop_front());
            end
            if (rsp_ch.valid && rsp_ch.ready) begin
                if (pending_inverses.size() == 0) begin
                    $display("%0t: unexpected result, got inverse %h invertible %b",
                             $time, rsp_ch.inverse, rsp_ch.invertible);
                    mismatches++;
                end else begin
                    want = pending_inverses.pop_front();
                    if (rsp_ch.inverse !== want.inverse) begin
                        $display("%0t: inverse expected %h got %h",
                                 $time, want.inverse, rsp_ch.inverse);
                        mismatches++;
                    end
                    if (rsp_ch.invertible !== want.invertible) begin
                        $display("%0t: invertible expected %b got %b",
                                 $time, want.invertible, rsp_ch.invertible);
                        mismatches++;
                    end
                end
            end
        end
    end

    // Hold until every queued request went in and every result came back.
    task automatic wait_idle();
        while (operands_to_send.size() != 0 || pending_inverses.size() != 0)
            @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    // Write the modulus while the block is idle; called on a falling edge.
    task automatic write_modulus(input logic [DEG:0] value);
        i_cfg_we    = 1'b1;
        i_cfg_data  = value;
        modulus_now = value;
        @(negedge i_clk);
        i_cfg_we    = 1'b0;
        @(negedge i_clk);
    endtask

    // Queue random operands, with zero, one and all-ones mixed in.
    task automatic push_random(input int count);
        int pick;
        for (int i = 0; i < count; i++) begin
            pick = $urandom_range(15);
            case (pick)
                0: operands_to_send.push_back('0);
                1: operands_to_send.push_back(DEG'(1));
                2: operands_to_send.push_back('1);
                default: operands_to_send.push_back(DEG'($urandom_range(0, (1 << DEG) - 1)));
            endcase
        end
    endtask

    initial begin : stimulus
        req_ch.valid   = 1'b0;
        req_ch.operand = '0;
        rsp_ch.ready   = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_data     = '0;
        i_rst_n        = 1'b0;
        modulus_now    = (DEG + 1)'(MODULUS_RESET);
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Reset modulus x^10+x^3+1: zero, one, field extremes, single bits, alternating.
        operands_to_send = '{10'h000, 10'h001, 10'h3FF, 10'h200, 10'h002,
                             10'h155, 10'h2AA, 10'h008, 10'h100, 10'h0F0};
        wait_idle();

        // Reducible modulus x^10: even operands share a factor x, odd ones invert.
        write_modulus(11'h400);
        operands_to_send = '{10'h000, 10'h001, 10'h002, 10'h003, 10'h3FF, 10'h200};
        wait_idle();

        // All-ones modulus, the top extreme of the register.
        write_modulus(11'h7FF);
        operands_to_send = '{10'h001, 10'h003, 10'h3FF, 10'h155};
        wait_idle();

        // Modulus below degree ten: the algorithm runs on the given bits as they are.
        write_modulus(11'h00B);
        operands_to_send = '{10'h3FF, 10'h005, 10'h001, 10'h00B, 10'h016};
        wait_idle();

        // Back to the default modulus, with a long stretch without idling.
        write_modulus((DEG + 1)'(MODULUS_RESET));
        steady = 1'b1;
        push_random(100);
        wait_idle();

        // Receiver holds off while the sender keeps offering requests.
        write_modulus((DEG + 1)'($urandom_range(1 << DEG, (1 << (DEG + 1)) - 1)));
        stall_go = 1'b1;
        push_random(40);
        wait_idle();
        steady = 1'b0;

        // Random degree-ten moduli with random idling on both sides.
        for (int p = 0; p < 6; p++) begin
            write_modulus((DEG + 1)'($urandom_range(1 << DEG, (1 << (DEG + 1)) - 1)));
            push_random(60);
            wait_idle();
        end

        // Give a stray result time to show up before the verdict.
        repeat (SETTLE) @(negedge i_clk);
        if (mismatches == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    initial begin : watchdog
        #(LIMIT_TIME);
        $display("simulation failed");
        $finish;
    end

endmodule
